// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold while out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`endif

// File: rtl/lpht_pkg.sv
package lpht_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_MAX_BYTES = 28;
  localparam int KEY_BITS      = 8 * KEY_MAX_BYTES;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISS     = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_NOT_LIVE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_e;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_HASH,
    FSM_PROBE,
    FSM_RESP
  } fsm_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key_hash;
    logic [4:0]  key_length;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [31:0] key_word3;
    logic [5:0]  slot_handle;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] slot_index;
    logic       compaction_advised;
    logic [6:0] live_count;
    logic [6:0] tombstone_count;
  } out_t;

  // Contents of one slot
  typedef struct packed {
    logic [63:0]         key_hash;
    logic [4:0]          key_length;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  // Byte mask of the valid key bytes
  function automatic logic [KEY_BITS-1:0] key_mask(input logic [4:0] len);
    logic [KEY_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_MAX_BYTES; i++) begin
      m[8*i +: 8] = {8{(5'(i) < len)}};
    end
    return m;
  endfunction

endpackage

// File: rtl/lpht_ram.sv
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/lpht_ctrl.sv
module lpht_ctrl #(
  parameter int CAPACITY = lpht_pkg::CAPACITY_DEF,
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lpht_pkg::in_t      in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lpht_pkg::out_t     out_o,
  output logic               rd_en_o,
  output logic [IDX_W-1:0]   rd_addr_o,
  input  logic [1:0]         st_rd_data_i,
  input  lpht_pkg::entry_t   dt_rd_data_i,
  output logic [IDX_W-1:0]   wr_addr_o,
  output logic               st_wr_en_o,
  output logic [1:0]         st_wr_data_o,
  output logic               dt_wr_en_o,
  output lpht_pkg::entry_t   dt_wr_data_o
);

  import lpht_pkg::*;

  localparam int  CW   = $clog2(CAPACITY + 1);
  localparam bit  POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);

  fsm_e               fsm_q, fsm_d;
  in_t                item_q, item_d;
  logic [IDX_W-1:0]   s_q, s_d;
  logic [CW-1:0]      n_q, n_d;
  logic [2:0]         chunk_q, chunk_d;
  logic [IDX_W-1:0]   rem_q, rem_d;
  logic [63:0]        hsh_q, hsh_d;
  logic [CW-1:0]      live_q, live_d;
  logic [CW-1:0]      tomb_q, tomb_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  status_e            res_status_q, res_status_d;
  logic [5:0]         res_index_q, res_index_d;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [KEY_BITS-1:0] key_in;
  logic                full_now;
  logic                last_probe;
  logic [IDX_W-1:0]    s_next;
  logic                key_match;
  logic [IDX_W:0]      rem_v;

  assign key_in     = {item_q.key_word3, item_q.key_word2, item_q.key_word1, item_q.key_word0};
  assign full_now   = ((CW+2)'(live_q) * (CW+2)'(3)) > (CW+2)'(2 * CAPACITY);
  assign last_probe = (n_q == CW'(CAPACITY - 1));
  assign s_next     = (s_q == IDX_W'(CAPACITY - 1)) ? '0 : s_q + 1'b1;
  assign key_match  = (dt_rd_data_i.key_hash == item_q.key_hash) &&
                      (dt_rd_data_i.key_length == item_q.key_length) &&
                      (((dt_rd_data_i.key ^ key_in) & key_mask(item_q.key_length)) == '0);

  // Fold eight hash bits into the running remainder, most significant first
  always_comb begin
    rem_v = {1'b0, rem_q};
    for (int b = 7; b >= 0; b--) begin
      rem_v = {rem_v[IDX_W-1:0], hsh_q[56 + b]};
      if (rem_v >= (IDX_W+1)'(CAPACITY)) begin
        rem_v = rem_v - (IDX_W+1)'(CAPACITY);
      end
    end
  end

  // Next state and memory requests
  always_comb begin
    fsm_d        = fsm_q;
    item_d       = item_q;
    s_d          = s_q;
    n_d          = n_q;
    chunk_d      = chunk_q;
    rem_d        = rem_q;
    hsh_d        = hsh_q;
    live_d       = live_q;
    tomb_d       = tomb_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    rd_en_o      = 1'b0;
    rd_addr_o    = s_q;
    wr_addr_o    = s_q;
    st_wr_en_o   = 1'b0;
    st_wr_data_o = SLOT_EMPTY;
    dt_wr_en_o   = 1'b0;
    dt_wr_data_o = '{key_hash: item_q.key_hash, key_length: item_q.key_length, key: key_in};

    case (fsm_q)
      FSM_CLEAR: begin
        // Sweep the slot states to empty
        st_wr_en_o = 1'b1;
        wr_addr_o  = clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == IDX_W'(CAPACITY - 1)) begin
          fsm_d = FSM_IDLE;
        end
      end

      FSM_IDLE: begin
        if (in_valid_i) begin
          item_d = in_i;
          if (in_i.key_length > 5'(KEY_MAX_BYTES)) begin
            item_d.key_length = 5'(KEY_MAX_BYTES);
          end
          n_d         = '0;
          chunk_d     = '0;
          rem_d       = '0;
          hsh_d       = in_i.key_hash;
          res_index_d = '0;
          case (mode_e'(in_i.mode))
            MODE_INSERT, MODE_LOOKUP: begin
              if ((mode_e'(in_i.mode) == MODE_INSERT) && full_now) begin
                res_status_d = STATUS_FULL;
                fsm_d        = FSM_RESP;
              end else if (POW2) begin
                s_d       = in_i.key_hash[IDX_W-1:0];
                rd_en_o   = 1'b1;
                rd_addr_o = in_i.key_hash[IDX_W-1:0];
                fsm_d     = FSM_PROBE;
              end else begin
                fsm_d = FSM_HASH;
              end
            end
            MODE_DELETE: begin
              res_index_d = in_i.slot_handle;
              if (int'(in_i.slot_handle) < CAPACITY) begin
                s_d       = IDX_W'(in_i.slot_handle);
                rd_en_o   = 1'b1;
                rd_addr_o = IDX_W'(in_i.slot_handle);
                fsm_d     = FSM_PROBE;
              end else begin
                res_status_d = STATUS_NOT_LIVE;
                fsm_d        = FSM_RESP;
              end
            end
            default: begin
              res_status_d = STATUS_MISS;
              fsm_d        = FSM_RESP;
            end
          endcase
        end
      end

      FSM_HASH: begin
        // Reduce the hash modulo the capacity, one byte per cycle
        rem_d   = rem_v[IDX_W-1:0];
        hsh_d   = hsh_q << 8;
        chunk_d = chunk_q + 1'b1;
        if (chunk_q == 3'd7) begin
          s_d       = rem_v[IDX_W-1:0];
          rd_en_o   = 1'b1;
          rd_addr_o = rem_v[IDX_W-1:0];
          fsm_d     = FSM_PROBE;
        end
      end

      FSM_PROBE: begin
        case (mode_e'(item_q.mode))
          MODE_INSERT: begin
            if (st_rd_data_i != SLOT_LIVE) begin
              // Claim the slot
              st_wr_en_o   = 1'b1;
              st_wr_data_o = SLOT_LIVE;
              dt_wr_en_o   = 1'b1;
              if ((st_rd_data_i == SLOT_TOMB) && (tomb_q != '0)) begin
                tomb_d = tomb_q - 1'b1;
              end
              live_d       = live_q + 1'b1;
              res_status_d = STATUS_OK;
              res_index_d  = 6'(s_q);
              fsm_d        = FSM_RESP;
            end else if (last_probe) begin
              res_status_d = STATUS_FULL;
              fsm_d        = FSM_RESP;
            end else begin
              s_d       = s_next;
              n_d       = n_q + 1'b1;
              rd_en_o   = 1'b1;
              rd_addr_o = s_next;
            end
          end
          MODE_LOOKUP: begin
            if (st_rd_data_i == SLOT_EMPTY) begin
              res_status_d = STATUS_MISS;
              fsm_d        = FSM_RESP;
            end else if ((st_rd_data_i == SLOT_LIVE) && key_match) begin
              res_status_d = STATUS_OK;
              res_index_d  = 6'(s_q);
              fsm_d        = FSM_RESP;
            end else if (last_probe) begin
              res_status_d = STATUS_MISS;
              fsm_d        = FSM_RESP;
            end else begin
              s_d       = s_next;
              n_d       = n_q + 1'b1;
              rd_en_o   = 1'b1;
              rd_addr_o = s_next;
            end
          end
          MODE_DELETE: begin
            if (st_rd_data_i == SLOT_LIVE) begin
              st_wr_en_o   = 1'b1;
              st_wr_data_o = SLOT_TOMB;
              if (live_q != '0) begin
                live_d = live_q - 1'b1;
              end
              tomb_d       = tomb_q + 1'b1;
              res_status_d = STATUS_OK;
            end else begin
              res_status_d = STATUS_NOT_LIVE;
            end
            fsm_d = FSM_RESP;
          end
          default: begin
            res_status_d = STATUS_MISS;
            fsm_d        = FSM_RESP;
          end
        endcase
      end

      FSM_RESP: begin
        // Load the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_d.status             = res_status_q;
          out_d.slot_index         = res_index_q;
          out_d.compaction_advised = ((CW+2)'(tomb_q) * (CW+2)'(3)) > (CW+2)'(CAPACITY);
          out_d.live_count         = 7'(live_q);
          out_d.tombstone_count    = 7'(tomb_q);
          out_valid_d              = 1'b1;
          fsm_d                    = FSM_IDLE;
        end
      end

      default: begin
        fsm_d = FSM_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= FSM_CLEAR;
      live_q      <= '0;
      tomb_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      live_q      <= live_d;
      tomb_q      <= tomb_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    s_q          <= s_d;
    n_q          <= n_d;
    chunk_q      <= chunk_d;
    rem_q        <= rem_d;
    hsh_q        <= hsh_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    out_q        <= out_d;
  end

  assign in_stall_o  = (fsm_q != FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing and tombstones.
// Input channel (in_valid_i / in_stall_o / in_i) takes one transaction per
// operation: insert, lookup, or delete by slot handle. Output channel
// (out_valid_o / out_stall_i / out_o) returns exactly one result per
// transaction, with status, slot index and the live and tombstone counts.
// Insert and lookup: an accept step, then a reduction of the eight hash
// bytes modulo CAPACITY when it is not a power of two, then a probe of
// each slot in the chain, then loading the result; the next transaction
// is taken right after the result is loaded.
// The probe rate is one slot per cycle, set by the single read port of the
// slot state and slot contents memories.
// Delete reads the addressed slot state before loading the result; full
// refusal, the unused mode and an out-of-range handle load it directly.
// After reset in_stall_o stays high while every slot is cleared to empty.
// A stalled receiver holds the result in the output register; a new
// transaction is still taken and runs until its own result is ready.
`include "assert_macros.svh"

module linear_probe_hash_table #(
  parameter int CAPACITY = lpht_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lpht_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lpht_pkg::out_t out_o
);

  import lpht_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [1:0]       st_rd_data;
  entry_t           dt_rd_data;
  logic [IDX_W-1:0] wr_addr;
  logic             st_wr_en;
  logic [1:0]       st_wr_data;
  logic             dt_wr_en;
  entry_t           dt_wr_data;

  // Operation sequencer
  lpht_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_i         (in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_o),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .st_rd_data_i (st_rd_data),
    .dt_rd_data_i (dt_rd_data),
    .wr_addr_o    (wr_addr),
    .st_wr_en_o   (st_wr_en),
    .st_wr_data_o (st_wr_data),
    .dt_wr_en_o   (dt_wr_en),
    .dt_wr_data_o (dt_wr_data)
  );

  // Slot state memory
  lpht_ram #(
    .WIDTH(2),
    .DEPTH(CAPACITY)
  ) u_state_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (st_rd_data),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (st_wr_data)
  );

  // Slot contents memory
  lpht_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_data_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (dt_rd_data),
    .wr_en_i   (dt_wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (dt_wr_data)
  );

  `ASSERT_NEVER(a_no_rd_wr_overlap, clk_i, rst_ni, rd_en && (st_wr_en || dt_wr_en))
  `ASSERT_IMPLIES(a_result_while_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))
  `ASSERT_IMPLIES(a_counts_bounded, clk_i, rst_ni, out_valid_o, (int'(out_o.live_count) + int'(out_o.tombstone_count)) <= CAPACITY)
  `ASSERT_IMPLIES(a_full_index_zero, clk_i, rst_ni, out_valid_o && (out_o.status == STATUS_FULL), out_o.slot_index == 6'd0)

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import lpht_pkg::*;

  localparam int CAP = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  linear_probe_hash_table #(.CAPACITY(CAP)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_o(out_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predicted table contents
  slot_e       tbl_state [CAP];
  logic [63:0] tbl_hash  [CAP];
  logic [4:0]  tbl_len   [CAP];
  logic [223:0] tbl_key  [CAP];
  int          n_live, n_tomb;

  in_t  op_queue [$];
  out_t result_queue [$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   src_idle_pct = 31;
  int   dst_idle_pct = 73;
  bit   hold_src = 1'b0;
  int   n_ins, n_look, n_del, n_full, n_hit;

  function automatic bit keys_equal(logic [223:0] x, logic [223:0] y, int len);
    for (int i = 0; i < len; i++) begin
      if (x[8*i +: 8] != y[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one operation to the predicted table and return its result
  function automatic out_t table_apply(in_t t);
    out_t r;
    int s, len;
    logic [223:0] k;
    r = '0;
    r.status = STATUS_MISS;
    len = (t.key_length > 28) ? 28 : t.key_length;
    k = {t.key_word3, t.key_word2, t.key_word1, t.key_word0};
    s = t.key_hash % CAP;
    case (mode_e'(t.mode))
      MODE_INSERT: begin
        n_ins++;
        r.status = STATUS_FULL;
        if (!(3 * n_live > 2 * CAP)) begin
          for (int n = 0; n < CAP; n++) begin
            if (tbl_state[s] != SLOT_LIVE) begin
              if (tbl_state[s] == SLOT_TOMB && n_tomb > 0) n_tomb--;
              tbl_state[s] = SLOT_LIVE;
              tbl_hash[s] = t.key_hash;
              tbl_len[s] = 5'(len);
              tbl_key[s] = k;
              n_live++;
              r.status = STATUS_OK;
              r.slot_index = 6'(s);
              break;
            end
            s = (s + 1) % CAP;
          end
        end
        if (r.status == STATUS_FULL) n_full++;
      end
      MODE_LOOKUP: begin
        n_look++;
        for (int n = 0; n < CAP; n++) begin
          if (tbl_state[s] == SLOT_EMPTY) break;
          if (tbl_state[s] == SLOT_LIVE && tbl_hash[s] == t.key_hash &&
              tbl_len[s] == len && keys_equal(tbl_key[s], k, len)) begin
            r.status = STATUS_OK;
            r.slot_index = 6'(s);
            n_hit++;
            break;
          end
          s = (s + 1) % CAP;
        end
      end
      MODE_DELETE: begin
        n_del++;
        r.slot_index = t.slot_handle;
        if (tbl_state[t.slot_handle] == SLOT_LIVE) begin
          tbl_state[t.slot_handle] = SLOT_TOMB;
          if (n_live > 0) n_live--;
          n_tomb++;
          r.status = STATUS_OK;
        end else begin
          r.status = STATUS_NOT_LIVE;
        end
      end
      default: ;
    endcase
    r.compaction_advised = (3 * n_tomb > CAP);
    r.live_count = 7'(n_live);
    r.tombstone_count = 7'(n_tomb);
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Build an operation; live keys come from a small pool so lookups hit
  logic [63:0] pool_hash [16];
  logic [223:0] pool_key [16];
  logic [4:0] pool_len [16];

  function automatic in_t make_op(mode_e m, int p);
    in_t t;
    t = '0;
    t.mode = m;
    t.key_hash = pool_hash[p];
    t.key_length = pool_len[p];
    {t.key_word3, t.key_word2, t.key_word1, t.key_word0} = pool_key[p];
    t.slot_handle = 6'($urandom_range(0, 63));
    return t;
  endfunction

  function automatic in_t rand_op();
    in_t t;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) t = make_op(MODE_INSERT, $urandom_range(0, 15));
    else if (r < 75) t = make_op(MODE_LOOKUP, $urandom_range(0, 15));
    else if (r < 97) t = make_op(MODE_DELETE, $urandom_range(0, 15));
    else t = make_op(MODE_NOP, $urandom_range(0, 15));
    // occasionally fully random key content and lengths past the maximum
    if ($urandom_range(0, 9) == 0) begin
      t.key_hash = {$urandom, $urandom};
      t.key_length = 5'($urandom_range(0, 31));
      t.key_word0 = {$urandom, $urandom};
      t.key_word1 = {$urandom, $urandom};
      t.key_word2 = {$urandom, $urandom};
      t.key_word3 = $urandom;
    end
    return t;
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Driver: present the next pending transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        result_queue.push_back(table_apply(in_i));
        void'(op_queue.pop_front());
      end
      if ((!in_valid_i || !in_stall_o) ) begin
        if (op_queue.size() > 0 && !hold_src && !chance(src_idle_pct)) begin
          in_valid_i <= 1'b1;
          in_i <= op_queue[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (result_queue.size() == 0) begin
          report("unexpected result", 64'(out_o), 64'd0);
        end else begin
          want = result_queue.pop_front();
          if (out_o.status != want.status) report("status", out_o.status, want.status);
          if (out_o.slot_index != want.slot_index)
            report("slot_index", out_o.slot_index, want.slot_index);
          if (out_o.compaction_advised != want.compaction_advised)
            report("compaction", out_o.compaction_advised, want.compaction_advised);
          if (out_o.live_count != want.live_count)
            report("live_count", out_o.live_count, want.live_count);
          if (out_o.tombstone_count != want.tombstone_count)
            report("tombstone_count", out_o.tombstone_count, want.tombstone_count);
        end
      end
      out_stall_i <= chance(dst_idle_pct);
    end
  end

  task automatic wait_drain();
    while (op_queue.size() > 0 || in_valid_i || result_queue.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    in_t t;
    for (int i = 0; i < CAP; i++) tbl_state[i] = SLOT_EMPTY;
    n_live = 0;
    n_tomb = 0;
    n_ins = 0; n_look = 0; n_del = 0; n_full = 0; n_hit = 0;
    for (int p = 0; p < 16; p++) begin
      // few home slots so probe chains collide and wrap
      pool_hash[p] = {$urandom, $urandom};
      if (p < 8) pool_hash[p][5:0] = 6'd62 + p[0];
      pool_key[p] = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      pool_len[p] = 5'($urandom_range(0, 31));
    end
    pool_hash[0] = '1;
    pool_len[0] = 28;
    pool_key[0] = '1;
    pool_hash[1] = '0;
    pool_len[1] = 0;
    pool_key[1] = '0;
    pool_len[2] = 31;
    pool_hash[3] = pool_hash[2];
    pool_key[3] = pool_key[2];
    pool_len[3] = 28;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every mode, duplicates, tombstones, misses
    op_queue.push_back(make_op(MODE_LOOKUP, 0));
    op_queue.push_back(make_op(MODE_DELETE, 0));
    op_queue.push_back(make_op(MODE_INSERT, 0));
    op_queue.push_back(make_op(MODE_INSERT, 0));
    op_queue.push_back(make_op(MODE_INSERT, 1));
    op_queue.push_back(make_op(MODE_INSERT, 2));
    op_queue.push_back(make_op(MODE_LOOKUP, 3));
    op_queue.push_back(make_op(MODE_LOOKUP, 2));
    t = make_op(MODE_LOOKUP, 2);
    t.key_word3 = ~t.key_word3;
    op_queue.push_back(t);
    t = make_op(MODE_LOOKUP, 1);
    t.key_word0 = '1;
    op_queue.push_back(t);
    op_queue.push_back(make_op(MODE_LOOKUP, 0));
    t = make_op(MODE_DELETE, 0);
    t.slot_handle = 6'd63;
    op_queue.push_back(t);
    op_queue.push_back(t);
    op_queue.push_back(make_op(MODE_LOOKUP, 0));
    op_queue.push_back(make_op(MODE_INSERT, 7));
    op_queue.push_back(make_op(MODE_NOP, 5));
    t = '1;
    op_queue.push_back(t);
    wait_drain();

    // Fill past two thirds to reach the full refusal
    for (int i = 0; i < 48; i++) op_queue.push_back(make_op(MODE_INSERT, i % 16));
    wait_drain();
    // Delete heavily to raise the tombstone count over one third
    for (int i = 0; i < 64; i++) begin
      t = make_op(MODE_DELETE, 0);
      t.slot_handle = 6'(i);
      op_queue.push_back(t);
    end
    for (int i = 0; i < 8; i++) op_queue.push_back(make_op(MODE_LOOKUP, i));

    // Random phases with the idle mix changing
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 73 : 0;
      dst_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 31 : 0;
      for (int i = 0; i < 500; i++) op_queue.push_back(rand_op());
      // stretch with no idling inside each phase
      for (int i = 0; i < 40; i++) op_queue.push_back(rand_op());
      while (op_queue.size() > 40) @(posedge clk_i);
      src_idle_pct = 0;
      dst_idle_pct = 0;
      wait_drain();
      // keep the sender held off once everything is back
      hold_src = 1'b1;
      repeat (5) @(posedge clk_i);
      hold_src = 1'b0;
    end
    wait_drain();
    repeat (200) @(posedge clk_i);

    $display("covered %0d inserts (%0d refused full), %0d lookups (%0d hits), %0d deletes",
             n_ins, n_full, n_look, n_hit, n_del);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && result_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

endmodule
